// ----- design/nsa_pkg.sv -----
package nsa_pkg;

  localparam logic signed [63:0] SAT_MAX_S64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN_S64 = {1'b1, {63{1'b0}}};

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned DIV_BITS = 64;
  localparam int unsigned STEP_W   = $clog2(DIV_BITS);
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [63:0] value;
    logic signed [63:0] partner_error;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] final_sum;
    logic signed [63:0] raw_sum;
    logic signed [63:0] error_out;
    logic signed [63:0] mean;
    logic               overflow_flag;
    logic               underflow_flag;
    logic               domain_flag;
  } out_item_t;

  // Batch totals handed from the accumulator to the mean divider.
  typedef struct packed {
    logic signed [63:0] fin;
    logic signed [63:0] raw;
    logic signed [63:0] err;
    logic [CNT_W-1:0]   count;
    logic               ovf;
    logic               unf;
    logic               dom;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic signed [63:0] wrap;
    logic               ovf;
    logic               unf;
  } sat_res_t;

  function automatic sat_res_t sat_add(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    sat_res_t res;
    res.wrap = a + b;
    res.ovf  = !a[63] && !b[63] && res.wrap[63];
    res.unf  = a[63] && b[63] && !res.wrap[63];
    if (res.ovf) begin
      res.sum = SAT_MAX_S64;
    end else if (res.unf) begin
      res.sum = SAT_MIN_S64;
    end else begin
      res.sum = res.wrap;
    end
    return res;
  endfunction

endpackage

// ----- design/nsa_front.sv -----
module nsa_front import nsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  input  logic [CNT_W-1:0] batch_limit_i,
  input  q_status_t        q_status_i,
  output logic             push_o,
  output snap_t            push_data_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ERRSUB = 3'd1;
  localparam logic [2:0] S_ERRADD = 3'd2;
  localparam logic [2:0] S_MERGE  = 3'd3;
  localparam logic [2:0] S_FINAL  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic signed [63:0] rs_q, rs_d;
  logic signed [63:0] err_q, err_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               unf_q, unf_d;
  logic signed [63:0] wsum_q, wsum_d;
  logic signed [63:0] e_q, e_d;
  logic signed [63:0] pe_q, pe_d;
  logic               merge_q, merge_d;
  logic               last_q, last_d;

  sat_res_t add_v, add_e, add_pe, add_fin;
  logic     accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    add_v   = sat_add(rs_q, in_data_i.value);
    add_e   = sat_add(err_q, e_q);
    add_pe  = sat_add(err_q, pe_q);
    add_fin = sat_add(rs_q, err_q);
  end

  always_comb begin
    push_data_o.fin   = add_fin.sum;
    push_data_o.raw   = rs_q;
    push_data_o.err   = err_q;
    push_data_o.count = cnt_q;
    push_data_o.ovf   = ovf_q | add_fin.ovf;
    push_data_o.unf   = unf_q | add_fin.unf;
    push_data_o.dom   = cnt_q > batch_limit_i;
  end

  assign push_o = (state_q == S_FINAL) && !q_status_i.full;

  always_comb begin
    state_d = state_q;
    rs_d    = rs_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    unf_d   = unf_q;
    wsum_d  = wsum_q;
    e_d     = e_q;
    pe_d    = pe_q;
    merge_d = merge_q;
    last_d  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rs_d    = add_v.sum;
          wsum_d  = add_v.wrap;
          // Saturating magnitudes only matter through their overflow side effect:
          // the wrapped error term is the same whichever operand is larger.
          ovf_d   = ovf_q | add_v.ovf | (rs_q == SAT_MIN_S64) |
                    (in_data_i.value == SAT_MIN_S64);
          unf_d   = unf_q | add_v.unf;
          pe_d    = in_data_i.partner_error;
          merge_d = (in_data_i.opcode == OP_MERGE);
          last_d  = in_data_i.last_item;
          if (cnt_q != {CNT_W{1'b1}}) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = S_ERRSUB;
        end
      end
      S_ERRSUB: begin
        e_d     = wsum_q - rs_q;
        state_d = S_ERRADD;
      end
      S_ERRADD: begin
        err_d = add_e.sum;
        ovf_d = ovf_q | add_e.ovf;
        unf_d = unf_q | add_e.unf;
        if (merge_q) begin
          state_d = S_MERGE;
        end else if (last_q) begin
          state_d = S_FINAL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MERGE: begin
        err_d   = add_pe.sum;
        ovf_d   = ovf_q | add_pe.ovf;
        unf_d   = unf_q | add_pe.unf;
        state_d = last_q ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        if (push_o) begin
          rs_d    = '0;
          err_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          unf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rs_q    <= '0;
      err_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      unf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rs_q    <= rs_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      unf_q   <= unf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wsum_q  <= wsum_d;
    e_q     <= e_d;
    pe_q    <= pe_d;
    merge_q <= merge_d;
    last_q  <= last_d;
  end

  a_clear_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (cnt_q == '0) && (rs_q == '0) && (err_q == '0) && !ovf_q && !unf_q)
    else $error("accumulator state not cleared after batch hand-off");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cnt_q != '0))
    else $error("batch handed off with zero item count");

endmodule

// ----- design/nsa_queue.sv -----
module nsa_queue import nsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  snap_t     push_data_i,
  input  logic      pop_i,
  output snap_t     pop_data_o,
  output q_status_t status_o
);

  snap_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   fill_q;

  assign status_o.full  = (fill_q == (QPTR_W+1)'(QDEPTH));
  assign status_o.empty = (fill_q == '0);
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

endmodule

// ----- design/nsa_back.sv -----
module nsa_back import nsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  snap_t     pop_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  snap_t               snap_q;
  logic                neg_q;
  logic [DIV_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [CNT_W:0]      rem_sh, rem_diff;
  logic                ge;
  logic                load_out;
  logic [DIV_BITS-1:0] mag;

  assign pop_o       = (state_q == B_IDLE) && !q_status_i.empty;
  assign load_out    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Divide the magnitude, restore the sign afterwards: truncation toward zero.
  assign mag      = pop_data_i.fin[63] ? (~pop_data_i.fin + 1'b1) : pop_data_i.fin;
  assign rem_sh   = {rem_q, quo_q[DIV_BITS-1]};
  assign ge       = rem_sh >= {1'b0, snap_q.count};
  assign rem_diff = rem_sh - {1'b0, snap_q.count};

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          quo_d   = mag;
          rem_d   = '0;
          step_d  = '0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        quo_d  = {quo_q[DIV_BITS-2:0], ge};
        rem_d  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_BITS - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    if (pop_o) begin
      snap_q <= pop_data_i;
      neg_q  <= pop_data_i.fin[63];
    end
    if (load_out) begin
      out_q.final_sum      <= snap_q.fin;
      out_q.raw_sum        <= snap_q.raw;
      out_q.error_out      <= snap_q.err;
      out_q.mean           <= neg_q ? (~quo_q + 1'b1) : quo_q;
      out_q.overflow_flag  <= snap_q.ovf;
      out_q.underflow_flag <= snap_q.unf;
      out_q.domain_flag    <= snap_q.dom;
    end
  end

  a_pop_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == B_DIV) && (step_q == '0))
    else $error("divider did not start on pop");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while held");

endmodule

// ----- design/neumaier_saturating_accumulator_unit.sv -----
// Saturating compensated accumulator with per-batch mean.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction per
// add or merge item. The front accumulator takes one state for each step of
// its saturating adder chain (sum, error subtract, error add, and for a merge
// item partner error add); a last item then waits in a final state until it
// can hand the batch totals to a two-entry queue.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction per
// batch. The back part pops a batch, divides the compensated sum by the item
// count in a restoring divider and loads the output register.
// Neither part takes a new item or batch before it is through with the last.
// The front keeps accumulating the next batch while the back divides; two
// finished batches can wait in the queue.
// Configuration: cfg_we_i writes cfg_data_i into the batch limit register;
// write it only while the block is idle.
// Reset clears the accumulator, the queue, the divider and the output valid;
// the batch limit returns to 65536. A stalled receiver holds the result in
// the output register; once the queue is full, the front stops accepting after its next last item.
module neumaier_saturating_accumulator_unit import nsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  logic [CNT_W-1:0] batch_limit_q;
  logic             push, pop;
  snap_t            push_data, pop_data;
  q_status_t        q_status;

  // Hold the batch limit; only the domain check reads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit_q <= CNT_W'(65536);
    end else if (cfg_we_i) begin
      batch_limit_q <= cfg_data_i;
    end
  end

  nsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .batch_limit_i (batch_limit_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  nsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  nsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the saturating compensated accumulator.
//
// An initial block plans the run: it fills a queue of items to send, phase by
// phase, and rewrites the batch limit between phases once the block has gone
// quiet. A clocked driver feeds those items to the input channel. A clocked
// predictor watches every accepted input transaction and, on a last item,
// pushes the batch result it expects. A clocked monitor pops the oldest
// expectation for every accepted output transaction and compares field by
// field. Both channels idle at random, except during one calm phase.
module testbench;
  import nsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 100;   // settling time once the last result is back
  localparam int unsigned IDLE_PCT    = 24;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 300;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;
  logic             cfg_we      = 1'b0;
  logic [CNT_W-1:0] cfg_data    = '0;

  // Items waiting to be driven, and batch results still owed by the block.
  in_item_t  items_to_send [$];
  out_item_t results_due   [$];

  // Predictor state: a private copy of the accumulator and its limit.
  logic signed [63:0] acc_sum    = '0;
  logic signed [63:0] acc_err    = '0;
  logic [CNT_W-1:0]   acc_count  = '0;
  logic               acc_ovf    = 1'b0;
  logic               acc_unf    = 1'b0;
  logic [CNT_W-1:0]   limit_copy = 32'd65536;

  bit          calm   = 1'b0;   // suppress idling on both sides
  int unsigned faults = 0;
  int unsigned cycles = 0;

  neumaier_saturating_accumulator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating add; raise the sticky flags of the predictor on clipping.
  function automatic logic signed [63:0] clip_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      if (a[63]) begin
        acc_unf = 1'b1;
        return SAT_MIN_S64;
      end
      acc_ovf = 1'b1;
      return SAT_MAX_S64;
    end
    return r;
  endfunction

  // Magnitude that clips the most negative value to the largest one.
  function automatic logic signed [63:0] clip_mag(input logic signed [63:0] x);
    if (x == SAT_MIN_S64) begin
      acc_ovf = 1'b1;
      return SAT_MAX_S64;
    end
    return (x < 0) ? -x : x;
  endfunction

  // Fold one item into the running totals; on a last item, hand back the
  // batch result and clear the totals.
  function automatic bit absorb_item(input in_item_t it, output out_item_t res);
    logic signed [63:0] v;
    logic signed [63:0] t;
    logic signed [63:0] mag_sum;
    logic signed [63:0] mag_val;
    logic signed [63:0] slip;
    logic signed [63:0] fin;
    logic signed [63:0] divisor;
    v       = it.value;
    t       = clip_add(acc_sum, v);
    mag_sum = clip_mag(acc_sum);
    mag_val = clip_mag(v);
    // Take the lost part from the larger operand, with wrapping arithmetic.
    if (mag_sum >= mag_val) begin
      slip = (acc_sum - t) + v;
    end else begin
      slip = (v - t) + acc_sum;
    end
    acc_sum = t;
    acc_err = clip_add(acc_err, slip);
    if (it.opcode == OP_MERGE) begin
      acc_err = clip_add(acc_err, it.partner_error);
    end
    if (acc_count != '1) begin
      acc_count = acc_count + 1'b1;
    end
    res = '0;
    if (!it.last_item) begin
      return 1'b0;
    end
    fin                = clip_add(acc_sum, acc_err);
    divisor            = {32'd0, acc_count};
    res.final_sum      = fin;
    res.raw_sum        = acc_sum;
    res.error_out      = acc_err;
    res.mean           = fin / divisor;
    res.overflow_flag  = acc_ovf;
    res.underflow_flag = acc_unf;
    res.domain_flag    = (acc_count > limit_copy);
    acc_sum   = '0;
    acc_err   = '0;
    acc_count = '0;
    acc_ovf   = 1'b0;
    acc_unf   = 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t make_item(input logic op, input logic signed [63:0] v,
                                         input logic signed [63:0] pe, input logic last);
    in_item_t it;
    it.opcode        = op;
    it.value         = v;
    it.partner_error = pe;
    it.last_item     = last;
    return it;
  endfunction

  // Operand mix: extremes, values near them, small values and full-width noise.
  function automatic logic signed [63:0] pick_word();
    logic signed [63:0] w;
    case ($urandom_range(0, 9))
      0: w = SAT_MAX_S64;
      1: w = SAT_MIN_S64;
      2: w = SAT_MAX_S64 - $urandom_range(0, 50);
      3: w = SAT_MIN_S64 + $urandom_range(0, 50);
      4: begin
        w = $urandom_range(0, 2000);
        w = w - 64'sd1000;
      end
      5: w = -64'sd1;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Driver: hold an item until it is taken, then advance or idle.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || in_ready)) begin
      if (items_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predictor: every accepted input transaction updates the private totals.
  always @(posedge clk_i) begin
    out_item_t res;
    if (rst_ni && in_valid && in_ready) begin
      if (absorb_item(in_data, res)) begin
        results_due.push_back(res);
      end
    end
  end

  // Receiver: stall at random outside the calm phase.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic report_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
    $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
    faults++;
  endtask

  // Monitor: compare each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, out_data);
        faults++;
      end else begin
        want = results_due.pop_front();
        if (out_data.final_sum !== want.final_sum)
          report_field("final_sum", want.final_sum, out_data.final_sum);
        if (out_data.raw_sum !== want.raw_sum)
          report_field("raw_sum", want.raw_sum, out_data.raw_sum);
        if (out_data.error_out !== want.error_out)
          report_field("error_out", want.error_out, out_data.error_out);
        if (out_data.mean !== want.mean)
          report_field("mean", want.mean, out_data.mean);
        if (out_data.overflow_flag !== want.overflow_flag)
          report_field("overflow_flag", 64'(want.overflow_flag),
                       64'(out_data.overflow_flag));
        if (out_data.underflow_flag !== want.underflow_flag)
          report_field("underflow_flag", 64'(want.underflow_flag),
                       64'(out_data.underflow_flag));
        if (out_data.domain_flag !== want.domain_flag)
          report_field("domain_flag", 64'(want.domain_flag),
                       64'(out_data.domain_flag));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every item is taken and every result is back, then let the
  // block settle.
  task automatic wait_until_quiet();
    while (items_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] lim);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    limit_copy = lim;
  endtask

  initial begin : plan
    logic [CNT_W-1:0] limits [PHASES];
    int unsigned      queued;
    int unsigned      run;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed batches under the reset limit.
    // A lone largest value.
    items_to_send.push_back(make_item(OP_ADD, SAT_MAX_S64, '0, 1'b1));
    // Clip high, then keep adding past the ceiling: the error term gathers the excess.
    items_to_send.push_back(make_item(OP_ADD, SAT_MAX_S64, '0, 1'b0));
    items_to_send.push_back(make_item(OP_ADD, 64'sd1, '0, 1'b0));
    items_to_send.push_back(make_item(OP_ADD, 64'sd10, '0, 1'b1));
    // Clip low; the magnitude of the most negative value also clips high.
    items_to_send.push_back(make_item(OP_ADD, SAT_MIN_S64, '0, 1'b0));
    items_to_send.push_back(make_item(OP_ADD, -64'sd1, '0, 1'b1));
    // Merges that drive the error total to its ceiling; an add ignores its partner error.
    items_to_send.push_back(make_item(OP_MERGE, 64'sd5, SAT_MAX_S64, 1'b0));
    items_to_send.push_back(make_item(OP_MERGE, -64'sd7, SAT_MAX_S64, 1'b0));
    items_to_send.push_back(make_item(OP_ADD, '0, SAT_MIN_S64, 1'b1));
    // Merges that drive the error total to its floor.
    items_to_send.push_back(make_item(OP_MERGE, SAT_MIN_S64, SAT_MIN_S64, 1'b0));
    items_to_send.push_back(make_item(OP_MERGE, -64'sd1, SAT_MIN_S64, 1'b1));
    // Negative mean truncated toward zero.
    items_to_send.push_back(make_item(OP_ADD, -64'sd5, '0, 1'b0));
    items_to_send.push_back(make_item(OP_ADD, 64'sd2, '0, 1'b1));
    // Alternating bit patterns on both words.
    items_to_send.push_back(make_item(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA,
                                      64'h5555_5555_5555_5555, 1'b0));
    items_to_send.push_back(make_item(OP_MERGE, 64'h5555_5555_5555_5555,
                                      64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    // Back-to-back single-item batches.
    items_to_send.push_back(make_item(OP_ADD, 64'sd7, '0, 1'b1));
    items_to_send.push_back(make_item(OP_ADD, -64'sd7, '0, 1'b1));
    items_to_send.push_back(make_item(OP_MERGE, 64'sd100, -64'sd3, 1'b1));
    wait_until_quiet();

    // Limit settings: zero flags every batch, the extremes, then small
    // limits that batches straddle.
    limits[0] = 32'd0;
    limits[1] = 32'd1;
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = 32'd3;
    limits[4] = 32'd6;
    limits[5] = $urandom_range(2, 12);

    for (int p = 0; p < PHASES; p++) begin
      write_limit(limits[p]);
      calm = (p == 3);
      @(negedge clk_i);
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 1; i <= run; i++) begin
          items_to_send.push_back(make_item(($urandom_range(0, 99) < 30) ? OP_MERGE : OP_ADD,
                                            pick_word(), pick_word(), i == run));
        end
        queued += run;
      end
      wait_until_quiet();
      calm = 1'b0;
    end

    if (results_due.size() != 0) begin
      $display("%0t missing %0d results: expected %p, actual none",
               $time, results_due.size(), results_due[0]);
      faults++;
    end
    if (faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/nsa_pkg.sv
design/nsa_front.sv
design/nsa_queue.sv
design/nsa_back.sv
design/neumaier_saturating_accumulator_unit.sv
tb/testbench.sv
